FILE: hdl/mts_pkg.sv
// shared types, codes and defaults for the minimum tracking stack
package mts_pkg;

  // default number of entries on each stack
  localparam int DEPTH_DEF = 64;

  // operation selector codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

  // one input item
  typedef struct packed {
    logic               func;
    logic signed [31:0] value;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] popped;
    logic signed [31:0] current_min;
    logic               min_valid;
    logic [6:0]         depth_now;
    logic [1:0]         status;
  } out_item_t;

endpackage

FILE: hdl/min_tracking_stack_top.sv
// minimum tracking stack: data stack plus auxiliary minimum stack in two rams
//
//   channel   direction   handshake            payload
//   in        input       in_valid/in_stall    in_item_t  (func, value)
//   out       output      out_valid/out_stall  out_item_t (popped, current_min,
//                                              min_valid, depth_now, status)
//
// a push and any rejected operation have their result registered at the transfer
// edge. a successful pop goes through the pop state: the tops below the cached
// tops come back from the rams in the cycle after the read is issued.
// rst is synchronous and empties both stacks; ram contents are not cleared.
// a new item is taken only in the idle state and only when the output
// register is empty or is being drained in the same cycle.
module min_tracking_stack_top
  import mts_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t             state;
  logic [CW-1:0]      data_count;
  logic [CW-1:0]      min_count;
  logic signed [31:0] data_top;
  logic signed [31:0] min_top;
  logic signed [31:0] popped_r;
  logic               pop_min_r;

  logic               in_accept;
  logic               is_push;
  logic               full;
  logic               empty;
  logic               data_we;
  logic               min_we;
  logic               pop_ok;
  logic               pop_min;
  logic               out_load;
  logic [CW-1:0]      data_count_inc;
  logic [CW-1:0]      data_rd_idx;
  logic [CW-1:0]      min_rd_idx;
  logic signed [31:0] data_rdata;
  logic signed [31:0] min_rdata;
  logic signed [31:0] push_min;
  logic signed [31:0] pop_min_new;

  // low seven bits of a count
  function automatic logic [6:0] depth7(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[6:0];
  endfunction

  // handshake
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  // operation decode
  assign is_push = (in_data.func == FUNC_PUSH);
  assign full    = (data_count == CW'(DEPTH));
  assign empty   = (data_count == '0);
  assign data_we = in_accept && is_push && !full;
  assign min_we  = data_we && ((min_count == '0) || (in_data.value <= min_top));
  assign pop_ok  = in_accept && !is_push && !empty;
  assign pop_min = (min_count != '0) && (data_top == min_top);

  // a result enters the output register this cycle
  assign out_load = (state == S_POP) || (in_accept && (is_push || empty));

  // addresses of the entries just below the cached tops
  assign data_count_inc = data_count + CW'(1);
  assign data_rd_idx    = data_count - CW'(2);
  assign min_rd_idx     = min_count - CW'(2);

  // minimum after a push and after a pop completes
  assign push_min    = min_we ? in_data.value : min_top;
  assign pop_min_new = pop_min_r ? min_rdata : min_top;

  mts_ram #(.DEPTH(DEPTH), .AW(AW)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_count[AW-1:0]),
    .wdata (in_data.value),
    .raddr (data_rd_idx[AW-1:0]),
    .rdata (data_rdata)
  );

  mts_ram #(.DEPTH(DEPTH), .AW(AW)) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (min_count[AW-1:0]),
    .wdata (in_data.value),
    .raddr (min_rd_idx[AW-1:0]),
    .rdata (min_rdata)
  );

  // sequencer, cached tops and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      data_count <= '0;
      min_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (is_push) begin
              out_data.popped      <= '0;
              out_data.min_valid   <= 1'b1;
              if (full) begin
                out_data.current_min <= min_top;
                out_data.depth_now   <= depth7(data_count);
                out_data.status      <= STATUS_PUSH_FULL;
              end else begin
                data_count           <= data_count_inc;
                data_top             <= in_data.value;
                if (min_we) begin
                  min_count <= min_count + CW'(1);
                  min_top   <= in_data.value;
                end
                out_data.current_min <= push_min;
                out_data.depth_now   <= depth7(data_count_inc);
                out_data.status      <= STATUS_OK;
              end
            end else if (empty) begin
              out_data.popped      <= '0;
              out_data.current_min <= '0;
              out_data.min_valid   <= 1'b0;
              out_data.depth_now   <= '0;
              out_data.status      <= STATUS_POP_EMPTY;
            end else if (pop_ok) begin
              data_count <= data_count - CW'(1);
              if (pop_min) begin
                min_count <= min_count - CW'(1);
              end
              popped_r  <= data_top;
              pop_min_r <= pop_min;
              state     <= S_POP;
            end
          end
        end
        S_POP: begin
          data_top <= data_rdata;
          if (pop_min_r) begin
            min_top <= min_rdata;
          end
          out_data.popped      <= popped_r;
          out_data.current_min <= (data_count != '0) ? pop_min_new : 32'sd0;
          out_data.min_valid   <= (data_count != '0);
          out_data.depth_now   <= depth7(data_count);
          out_data.status      <= STATUS_OK;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/mts_ram.sv
// single write port, single read port synchronous ram with registered read data
module mts_ram
  import mts_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/sv/min_tracking_stack_top_test.sv
// testbench for the minimum tracking stack: directed and random transfers checked by a predictor or fixed results
`timescale 1ns / 1ps

module min_tracking_stack_top_test;
  import mts_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1000;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 16;

  // receiver stall patterns
  localparam int STALL_NONE     = 0;
  localparam int STALL_COIN     = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_HEAVY    = 3;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t result;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predictor copy of both stacks
  logic signed [31:0] stk_vals[DEPTH_DEF];
  logic signed [31:0] stk_mins[DEPTH_DEF];
  int                 n_vals = 0;
  int                 n_mins = 0;

  out_item_t   expected_results[$];
  dir_row_t    dir_rows[$];
  int unsigned error_count = 0;
  int          burst_left  = 0;
  bit          steady      = 1'b0;

  min_tracking_stack_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // work out the result of one operation and update the stack copy
  function automatic out_item_t next_result(input in_item_t it);
    out_item_t r;
    r = '0;
    r.status = STATUS_OK;
    if (it.func == FUNC_PUSH) begin
      if (n_vals >= DEPTH_DEF) begin
        r.status = STATUS_PUSH_FULL;
      end else begin
        // equal values go on the minimum stack again
        if (n_mins == 0 || it.value <= stk_mins[n_mins-1]) begin
          if (n_mins < DEPTH_DEF) begin
            stk_mins[n_mins] = it.value;
            n_mins++;
          end
        end
        stk_vals[n_vals] = it.value;
        n_vals++;
      end
    end else begin
      if (n_vals == 0) begin
        r.status = STATUS_POP_EMPTY;
      end else begin
        n_vals--;
        r.popped = stk_vals[n_vals];
        if (n_mins > 0 && r.popped == stk_mins[n_mins-1]) n_mins--;
      end
    end
    r.current_min = (n_vals > 0 && n_mins > 0) ? stk_mins[n_mins-1] : '0;
    r.min_valid   = (n_vals > 0);
    r.depth_now   = n_vals[6:0];
    return r;
  endfunction

  // push values: wide random, small clustered, extremes, copies of the minimum
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $signed($urandom_range(0, 16)) - 8;
      6: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      7:          return (n_mins > 0) ? stk_mins[n_mins-1] : $urandom;
      default:    return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic add_free(input logic f, input logic signed [31:0] v);
    dir_row_t row;
    row.item.func  = f;
    row.item.value = v;
    row.fixed      = 1'b0;
    row.result     = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_fixed(input logic f, input logic signed [31:0] v,
                           input logic signed [31:0] e_pop, input logic signed [31:0] e_min,
                           input logic e_valid, input logic [6:0] e_depth,
                           input logic [1:0] e_status);
    dir_row_t row;
    row.item.func          = f;
    row.item.value         = v;
    row.fixed              = 1'b1;
    row.result.popped      = e_pop;
    row.result.current_min = e_min;
    row.result.min_valid   = e_valid;
    row.result.depth_now   = e_depth;
    row.result.status      = e_status;
    dir_rows.push_back(row);
  endtask

  // one input transfer, with a random gap at the start of each burst unless steady is set
  task automatic issue(input in_item_t item, input bit fixed, input out_item_t result);
    out_item_t pred;
    if (burst_left == 0) begin
      if (!steady) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = next_result(item);
    expected_results.push_back(fixed ? result : pred);
    burst_left--;
    @(negedge clk);
  endtask

  // hold off the sender until every pending result is out
  task automatic wait_all_results();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic report_field(input string name, input longint e, input longint a);
    error_count++;
    $display("%0t: %s mismatch, expected %0d got %0d", $time, name, e, a);
  endtask

  // stimulus
  initial begin
    in_item_t item;
    int       sent;
    int       session;
    int       mode_len;
    int       push_pct;
    bit       paused_mid;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part: empty pop, extremes, equal minimums, pop value ignored
    add_fixed(FUNC_POP,  32'sd0,        32'sd0, 32'sd0, 1'b0, 7'd0, STATUS_POP_EMPTY);
    add_fixed(FUNC_PUSH, 32'sh7fffffff, 32'sd0, 32'sh7fffffff, 1'b1, 7'd1, STATUS_OK);
    add_fixed(FUNC_PUSH, 32'sh80000000, 32'sd0, 32'sh80000000, 1'b1, 7'd2, STATUS_OK);
    add_fixed(FUNC_PUSH, 32'sh80000000, 32'sd0, 32'sh80000000, 1'b1, 7'd3, STATUS_OK);
    add_fixed(FUNC_POP,  32'sd0, 32'sh80000000, 32'sh80000000, 1'b1, 7'd2, STATUS_OK);
    add_fixed(FUNC_POP,  32'sd0, 32'sh80000000, 32'sh7fffffff, 1'b1, 7'd1, STATUS_OK);
    add_free(FUNC_PUSH, -32'sd1);
    add_free(FUNC_PUSH, 32'sd5);
    add_free(FUNC_PUSH, -32'sd1);
    add_free(FUNC_PUSH, 32'sd0);
    add_free(FUNC_PUSH, 32'sh55555555);
    add_free(FUNC_PUSH, 32'shaaaaaaaa);
    add_free(FUNC_POP,  32'sh12345678);
    add_free(FUNC_POP,  32'sd0);
    add_free(FUNC_POP,  32'sd0);
    add_free(FUNC_POP,  32'sd0);
    add_free(FUNC_POP,  32'sd0);
    add_free(FUNC_POP,  32'sd0);
    add_free(FUNC_POP,  32'sd0);
    add_fixed(FUNC_POP,  32'shdeadbeef, 32'sd0, 32'sd0, 1'b0, 7'd0, STATUS_POP_EMPTY);

    foreach (dir_rows[i]) issue(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);
    wait_all_results();

    // random part: a full fill and drain sweep, then mixed sessions
    sent       = 0;
    session    = 0;
    paused_mid = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (session == 0) begin
        push_pct = 100;
        mode_len = DEPTH_DEF + 8;
        steady   = 1'b1;
      end else if (session == 1) begin
        push_pct = 0;
        mode_len = DEPTH_DEF + 8;
        steady   = 1'b0;
      end else begin
        case ($urandom_range(0, 2))
          0:       push_pct = 50;
          1:       push_pct = 85;
          default: push_pct = 15;
        endcase
        mode_len = $urandom_range(20, 120);
        steady   = ($urandom_range(0, 3) == 0);
      end
      session++;
      repeat (mode_len) begin
        item.func  = ($urandom_range(1, 100) <= push_pct) ? FUNC_PUSH : FUNC_POP;
        item.value = (item.func == FUNC_PUSH) ? pick_value() : $urandom;
        issue(item, 1'b0, '0);
        sent++;
      end
      if (!paused_mid && sent >= RANDOM_ITEMS / 2) begin
        paused_mid = 1'b1;
        wait_all_results();
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver stall patterns, switched every so often
  always @(negedge clk) begin : stall_pattern
    static int stall_mode = STALL_NONE;
    static int mode_left  = 0;
    static int phase      = 0;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      mode_left  = $urandom_range(16, 160);
    end
    mode_left--;
    phase++;
    case (stall_mode)
      STALL_COIN:     out_stall = ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: out_stall = (phase % 3 == 0);
      STALL_HEAVY:    out_stall = ((phase % 11) < 7);
      default:        out_stall = 1'b0;
    endcase
  end

  // compare each output transfer with the oldest pending result
  always @(posedge clk) begin : check_results
    out_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: output transfer with nothing pending, expected none got %p",
                 $time, out_data);
      end else begin
        exp_item = expected_results.pop_front();
        if (out_data.popped !== exp_item.popped)
          report_field("popped", exp_item.popped, out_data.popped);
        if (out_data.current_min !== exp_item.current_min)
          report_field("current_min", exp_item.current_min, out_data.current_min);
        if (out_data.min_valid !== exp_item.min_valid)
          report_field("min_valid", exp_item.min_valid, out_data.min_valid);
        if (out_data.depth_now !== exp_item.depth_now)
          report_field("depth_now", exp_item.depth_now, out_data.depth_now);
        if (out_data.status !== exp_item.status)
          report_field("status", exp_item.status, out_data.status);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    static int idle_cycles = 0;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
